>>> hdl/prq_pkg.sv
// Shared types, constants and helpers for the priority ready queue.
// Depends on nothing; imported by every module of the block.
`timescale 1ns / 1ps

package prq_pkg;

    localparam int LEVELS = 32;
    localparam int SLOTS  = 64;
    localparam int LVL_W  = $clog2(LEVELS);
    localparam int ID_W   = $clog2(SLOTS);
    localparam int LINK_W = $clog2(SLOTS + 1);

    typedef logic [LINK_W-1:0] link_t;
    typedef logic [ID_W-1:0]   task_t;
    typedef logic [LVL_W-1:0]  level_t;

    // "none" link sits one past the last task slot
    localparam link_t NONE_LINK = LINK_W'(SLOTS);

    typedef enum logic [1:0] {
        FN_PUSH   = 2'd0,
        FN_POP    = 2'd1,
        FN_PEEK   = 2'd2,
        FN_REMOVE = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_BAD   = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_LINK
    } state_t;

    // Update broadcast to the row of level cells
    typedef struct packed {
        logic   wr_head;
        logic   wr_tail;
        level_t level;
        link_t  head_val;
        link_t  tail_val;
    } level_cmd_t;

    // Highest set bit of the level bitmap, zero when none is set
    function automatic level_t top_level(input logic [LEVELS-1:0] bm);
        level_t r;
        r = '0;
        for (int i = 0; i < LEVELS; i++)
        begin
            if (bm[i])
                r = LVL_W'(i);
        end
        return r;
    endfunction

endpackage

>>> hdl/priority_fifo_ready_queue.sv
// Priority ready queue: one FIFO of task ids per level, linked lists in RAM.
// Every operation presents its result beat from the execute state through the
// output register, later only while the receiver still holds the previous beat.
// New operations are taken only in idle, after execute and, for a push behind an
// existing tail, a second next-link write: registered link read, one write port.
// Reset (async, active low) empties every level and clears all queued flags.
`timescale 1ns / 1ps

module priority_fifo_ready_queue
    import prq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] func,
    input  logic [5:0] task_id,
    input  logic [4:0] task_prio,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [5:0] out_task,
    output logic [1:0] status,
    output logic       now_empty
);

    // Control state
    state_t state_reg, state_next;
    logic [SLOTS-1:0] queued_reg, queued_next;

    // Operation held for its execute cycle
    func_t  op_func_reg;
    task_t  op_task_reg;
    level_t op_level_reg;

    // Link memories: contents of a task's links matter only while it is
    // queued, and every push writes them, so they need no clearing pass
    link_t next_mem [SLOTS];
    link_t prev_mem [SLOTS];
    link_t rd_next_reg;
    link_t rd_prev_reg;
    logic  rd_en;
    task_t rd_addr;

    logic  nx_we, pv_we;
    task_t nx_waddr, pv_waddr;
    link_t nx_wdata, pv_wdata;

    // Output beat register
    logic    out_valid_reg, out_valid_next;
    task_t   out_task_reg, out_task_next;
    status_t status_reg, status_next;
    logic    now_empty_reg, now_empty_next;

    // Level row
    level_cmd_t        cmd;
    link_t             sel_head, sel_tail, top_head;
    level_t            top_lvl;
    logic [LEVELS-1:0] bitmap;

    prq_level_row u_row (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sel_level (op_level_reg),
        .sel_head  (sel_head),
        .sel_tail  (sel_tail),
        .top_lvl   (top_lvl),
        .top_head  (top_head),
        .bitmap    (bitmap)
    );

    logic  accept;
    logic  from_top;
    logic  slot_free;
    logic  bad_rm;
    link_t op_link;
    logic [LEVELS-1:0] others;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign from_top  = (func_t'(func) == FN_POP) || (func_t'(func) == FN_PEEK);
    assign slot_free = !out_valid_reg || out_ready;
    assign op_link   = {1'b0, op_task_reg};
    assign others    = bitmap & ~(LEVELS'(1) << op_level_reg);

    // Unlink checks: a list end must belong to the level named
    assign bad_rm = !queued_reg[op_task_reg]
                 || ((rd_prev_reg == NONE_LINK) && (sel_head != op_link))
                 || ((rd_next_reg == NONE_LINK) && (sel_tail != op_link));

    // Pop and peek take their task and level from the most urgent list
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_func_reg  <= func_t'(func);
            op_task_reg  <= from_top ? top_head[ID_W-1:0] : task_id;
            op_level_reg <= from_top ? top_lvl : task_prio;
        end
    end

    assign rd_en   = accept;
    assign rd_addr = from_top ? top_head[ID_W-1:0] : task_id;

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_next_reg <= next_mem[rd_addr];
            rd_prev_reg <= prev_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (nx_we)
            next_mem[nx_waddr] <= nx_wdata;
    end

    always_ff @(posedge clk)
    begin
        if (pv_we)
            prev_mem[pv_waddr] <= pv_wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            queued_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            queued_reg    <= queued_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_task_reg  <= out_task_next;
        status_reg    <= status_next;
        now_empty_reg <= now_empty_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        queued_next    = queued_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_task_next  = out_task_reg;
        status_next    = status_reg;
        now_empty_next = now_empty_reg;
        cmd            = '0;
        cmd.level      = op_level_reg;
        nx_we          = 1'b0;
        nx_waddr       = op_task_reg;
        nx_wdata       = NONE_LINK;
        pv_we          = 1'b0;
        pv_waddr       = op_task_reg;
        pv_wdata       = NONE_LINK;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = S_EXEC;
            end

            S_EXEC:
            begin
                // hold everything until the output register can take the beat
                if (slot_free)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                    out_task_next  = '0;
                    status_next    = ST_OK;
                    now_empty_next = (bitmap == '0);

                    unique case (op_func_reg)
                        FN_PUSH:
                        begin
                            if (queued_reg[op_task_reg])
                                status_next = ST_BAD;
                            else
                            begin
                                queued_next[op_task_reg] = 1'b1;
                                now_empty_next = 1'b0;
                                cmd.wr_tail    = 1'b1;
                                cmd.tail_val   = op_link;
                                pv_we          = 1'b1;
                                pv_wdata       = sel_tail;
                                nx_we          = 1'b1;
                                if (sel_tail == NONE_LINK)
                                begin
                                    cmd.wr_head  = 1'b1;
                                    cmd.head_val = op_link;
                                end
                                else
                                begin
                                    // chain behind the old tail, terminate next cycle
                                    nx_waddr   = sel_tail[ID_W-1:0];
                                    nx_wdata   = op_link;
                                    state_next = S_LINK;
                                end
                            end
                        end

                        FN_PEEK:
                        begin
                            if (bitmap == '0)
                                status_next = ST_EMPTY;
                            else
                                out_task_next = op_task_reg;
                        end

                        FN_POP, FN_REMOVE:
                        begin
                            if ((op_func_reg == FN_POP) && (bitmap == '0))
                                status_next = ST_EMPTY;
                            else if (bad_rm)
                                status_next = ST_BAD;
                            else
                            begin
                                if (op_func_reg == FN_POP)
                                    out_task_next = op_task_reg;
                                queued_next[op_task_reg] = 1'b0;
                                if (rd_prev_reg != NONE_LINK)
                                begin
                                    nx_we    = 1'b1;
                                    nx_waddr = rd_prev_reg[ID_W-1:0];
                                    nx_wdata = rd_next_reg;
                                end
                                else
                                begin
                                    cmd.wr_head  = 1'b1;
                                    cmd.head_val = rd_next_reg;
                                end
                                if (rd_next_reg != NONE_LINK)
                                begin
                                    pv_we    = 1'b1;
                                    pv_waddr = rd_next_reg[ID_W-1:0];
                                    pv_wdata = rd_prev_reg;
                                end
                                else
                                begin
                                    cmd.wr_tail  = 1'b1;
                                    cmd.tail_val = rd_prev_reg;
                                end
                                // only the named level can lose its last task
                                now_empty_next = (others == '0)
                                    && (cmd.wr_head ? (cmd.head_val == NONE_LINK)
                                                    : !bitmap[op_level_reg]);
                            end
                        end

                        default:
                        begin
                            status_next = ST_BAD;
                        end
                    endcase
                end
            end

            S_LINK:
            begin
                // terminate the new tail's forward link
                nx_we      = 1'b1;
                nx_waddr   = op_task_reg;
                nx_wdata   = NONE_LINK;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_task  = out_task_reg;
    assign status    = status_reg;
    assign now_empty = now_empty_reg;

    // The second link write always returns straight to idle
    a_link_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LINK) |=> (state_reg == S_IDLE))
        else $error("link write did not return to idle");

    // A new beat appears only from the execute step
    a_beat_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_EXEC))
        else $error("result beat raised outside execute");

    // An empty-queue result carries no task and reports the queue empty
    a_empty_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (status_reg == ST_EMPTY)) |-> (now_empty_reg && (out_task_reg == '0)))
        else $error("empty result with a task or a busy queue");

    // No queued task may exist while every level is empty
    a_bitmap_queued: assert property (@(posedge clk) disable iff (!rst_n)
        (bitmap == '0) |-> (queued_reg == '0))
        else $error("queued task with all levels empty");

endmodule

>>> hdl/prq_level_cell.sv
// One priority level: head and tail of its task list.
// Depends on prq_pkg.
`timescale 1ns / 1ps

module prq_level_cell
    import prq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  level_t     index,
    input  level_cmd_t cmd,
    output link_t      head,
    output link_t      tail,
    output logic       nonempty
);

    link_t head_reg;
    link_t tail_reg;
    logic  hit;

    assign hit = (cmd.level == index);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= NONE_LINK;
            tail_reg <= NONE_LINK;
        end
        else
        begin
            if (hit && cmd.wr_head)
                head_reg <= cmd.head_val;
            if (hit && cmd.wr_tail)
                tail_reg <= cmd.tail_val;
        end
    end

    assign head     = head_reg;
    assign tail     = tail_reg;
    // a level is marked busy exactly while its list has a head
    assign nonempty = (head_reg != NONE_LINK);

endmodule

>>> hdl/prq_level_row.sv
// Row of level cells with the urgency encoder and level selection.
// Depends on prq_pkg and prq_level_cell.
`timescale 1ns / 1ps

module prq_level_row
    import prq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  level_cmd_t        cmd,
    input  level_t            sel_level,
    output link_t             sel_head,
    output link_t             sel_tail,
    output level_t            top_lvl,
    output link_t             top_head,
    output logic [LEVELS-1:0] bitmap
);

    link_t heads [LEVELS];
    link_t tails [LEVELS];

    for (genvar g = 0; g < LEVELS; g++)
    begin : g_cell
        prq_level_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .index    (LVL_W'(g)),
            .cmd      (cmd),
            .head     (heads[g]),
            .tail     (tails[g]),
            .nonempty (bitmap[g])
        );
    end

    assign top_lvl  = top_level(bitmap);
    assign top_head = heads[top_lvl];
    assign sel_head = heads[sel_level];
    assign sel_tail = tails[sel_level];

endmodule

>>> tb/priority_fifo_ready_queue_tb.sv
// Self-checking testbench for the priority ready queue: directed and random push, pop,
// peek and remove beats are checked against an in-bench linked-list predictor.
// Depends on prq_pkg and priority_fifo_ready_queue from the hdl folder.
`timescale 1ns / 1ps

module priority_fifo_ready_queue_tb;
    import prq_pkg::*;

    // Expected contents of one result beat
    typedef struct {
        task_t   tsk;
        status_t st;
        logic    empty;
    } sched_result_t;

    logic       clk;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_ready;
    logic [1:0] func      = 2'd0;
    logic [5:0] task_id   = 6'd0;
    logic [4:0] task_prio = 5'd0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [5:0] out_task;
    logic [1:0] status;
    logic       now_empty;

    // Predictor copy of the queue: level bitmap, list ends and per-task links
    logic [LEVELS-1:0] lvl_map;
    link_t             lvl_head [LEVELS];
    link_t             lvl_tail [LEVELS];
    link_t             nxt [SLOTS];
    link_t             prv [SLOTS];
    bit                queued [SLOTS];
    level_t            queued_level [SLOTS];

    sched_result_t pending_results [$];
    int            errors    = 0;
    int            send_idle = 0;
    int            recv_idle = 0;

    priority_fifo_ready_queue dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .func      (func),
        .task_id   (task_id),
        .task_prio (task_prio),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_task  (out_task),
        .status    (status),
        .now_empty (now_empty)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Guard against a hung handshake; far beyond the slowest legal run
    initial
    begin
        #2_000_000;
        $display("priority_fifo_ready_queue_tb: FAIL");
        $finish;
    end

    // Unlink a task from its list. The end checks mirror the block: a task at the
    // head or tail of a list must be named with that list's level, while a task in
    // the middle is unlinked through its own links whatever level is given.
    function automatic status_t unlink_task(input task_t id, input level_t pr);
        link_t nx;
        link_t pv;
        if (!queued[id])
            return ST_BAD;
        nx = nxt[id];
        pv = prv[id];
        if (pv >= NONE_LINK && lvl_head[pr] != link_t'(id))
            return ST_BAD;
        if (nx >= NONE_LINK && lvl_tail[pr] != link_t'(id))
            return ST_BAD;
        if (pv < NONE_LINK)
            nxt[pv[ID_W-1:0]] = nx;
        else
            lvl_head[pr] = nx;
        if (nx < NONE_LINK)
            prv[nx[ID_W-1:0]] = pv;
        else
            lvl_tail[pr] = pv;
        nxt[id]    = NONE_LINK;
        prv[id]    = NONE_LINK;
        queued[id] = 1'b0;
        if (lvl_head[pr] >= NONE_LINK)
            lvl_map[pr] = 1'b0;
        return ST_OK;
    endfunction

    // Apply one accepted beat to the predictor and queue the result it implies
    function automatic void predict(input func_t f, input task_t id, input level_t pr);
        sched_result_t r;
        level_t        lv;
        link_t         tl;
        link_t         h;
        r.tsk = '0;
        r.st  = ST_OK;
        lv    = '0;
        case (f)
            FN_PUSH:
            begin
                if (queued[id])
                    r.st = ST_BAD;
                else
                begin
                    // append at the tail of the level
                    tl      = lvl_tail[pr];
                    nxt[id] = NONE_LINK;
                    prv[id] = tl;
                    if (tl < NONE_LINK)
                        nxt[tl[ID_W-1:0]] = link_t'(id);
                    else
                        lvl_head[pr] = link_t'(id);
                    lvl_tail[pr]     = link_t'(id);
                    queued[id]       = 1'b1;
                    queued_level[id] = pr;
                    lvl_map[pr]      = 1'b1;
                end
            end
            FN_REMOVE:
                r.st = unlink_task(id, pr);
            default:
            begin
                // pop and peek: head of the highest non-empty level
                if (lvl_map == '0)
                    r.st = ST_EMPTY;
                else
                begin
                    for (int i = 0; i < LEVELS; i++)
                    begin
                        if (lvl_map[i])
                            lv = level_t'(i);
                    end
                    h = lvl_head[lv];
                    if (h >= NONE_LINK)
                        r.st = ST_EMPTY;
                    else
                    begin
                        r.tsk = h[ID_W-1:0];
                        if (f == FN_POP)
                            void'(unlink_task(h[ID_W-1:0], lv));
                    end
                end
            end
        endcase
        r.empty = (lvl_map == '0);
        pending_results.push_back(r);
    endfunction

    // Offer one beat, idling first at the current sender rate. Called just after a
    // rising edge; valid stays high across back-to-back beats.
    task automatic send_op(input func_t f, input task_t id, input level_t pr);
        while ($urandom_range(0, 99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        func      <= f;
        task_id   <= id;
        task_prio <= pr;
        do
            @(posedge clk);
        while (!in_ready);
        predict(f, id, pr);
    endtask

    // Drop valid and hold until every expected beat has come back
    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    // Receiver: stall at random, compare every accepted beat with the oldest expectation
    always @(posedge clk)
    begin : result_check
        sched_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result beat: out_task %0d status %0d now_empty %0d",
                       out_task, status, now_empty);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (out_task !== want.tsk)
                begin
                    $error("out_task: expected %0d, got %0d", want.tsk, out_task);
                    errors++;
                end
                if (status !== want.st)
                begin
                    $error("status: expected %0d, got %0d", want.st, status);
                    errors++;
                end
                if (now_empty !== want.empty)
                begin
                    $error("now_empty: expected %0d, got %0d", want.empty, now_empty);
                    errors++;
                end
            end
        end
        out_ready <= ($urandom_range(0, 99) >= recv_idle);
    end

    // Pop and peek with nothing queued, and a remove of a task never pushed
    task automatic test_empty_queue();
        send_op(FN_POP, 6'd0, 5'd0);
        send_op(FN_PEEK, 6'd63, 5'd31);
        send_op(FN_REMOVE, 6'd5, 5'd2);
    endtask

    // Extreme ids and levels: the highest level wins, FIFO order within a level
    task automatic test_fifo_and_priority();
        send_op(FN_PUSH, 6'd0, 5'd0);
        send_op(FN_PUSH, 6'd63, 5'd31);
        send_op(FN_PUSH, 6'd10, 5'd31);
        send_op(FN_PEEK, 6'd0, 5'd0);
        send_op(FN_POP, 6'd0, 5'd0);
        send_op(FN_POP, 6'd0, 5'd0);
    endtask

    // A push of a task already queued must be refused and change nothing
    task automatic test_duplicate_push();
        send_op(FN_PUSH, 6'd0, 5'd17);
        send_op(FN_PUSH, 6'd0, 5'd0);
    endtask

    // Remove at the wrong level for a head and a tail, middle removal at any
    // level, then empty the queue completely
    task automatic test_remove_rules();
        send_op(FN_PUSH, 6'd20, 5'd7);
        send_op(FN_PUSH, 6'd21, 5'd7);
        send_op(FN_PUSH, 6'd22, 5'd7);
        send_op(FN_REMOVE, 6'd20, 5'd3);
        send_op(FN_REMOVE, 6'd22, 5'd0);
        send_op(FN_REMOVE, 6'd21, 5'd31);
        send_op(FN_REMOVE, 6'd0, 5'd0);
        send_op(FN_POP, 6'd0, 5'd0);
        send_op(FN_POP, 6'd0, 5'd0);
        send_op(FN_PEEK, 6'd0, 5'd0);
    endtask

    // Random mix weighted towards filling the lists, so that long chains, middle
    // removals and dense bitmaps all occur; pause once mid-run if asked
    task automatic test_random_mix(input int n, input bit hold_off);
        int     r;
        int     start;
        int     pick;
        task_t  id;
        level_t pr;
        for (int i = 0; i < n; i++)
        begin
            if (hold_off && i == n / 2)
                drain_results();
            r  = $urandom_range(0, 99);
            id = task_t'($urandom_range(0, SLOTS - 1));
            if ($urandom_range(0, 1))
                pr = level_t'($urandom_range(0, LEVELS - 1));
            else
                pr = level_t'($urandom_range(0, 3));
            if (r < 45)
                send_op(FN_PUSH, id, pr);
            else if (r < 65)
                send_op(FN_POP, id, pr);
            else if (r < 75)
                send_op(FN_PEEK, id, pr);
            else
            begin
                // mostly target a queued task, usually at its own level
                pick = -1;
                if ($urandom_range(0, 3) != 0)
                begin
                    start = $urandom_range(0, SLOTS - 1);
                    for (int k = 0; k < SLOTS; k++)
                    begin
                        if (pick < 0 && queued[(start + k) % SLOTS])
                            pick = (start + k) % SLOTS;
                    end
                end
                if (pick >= 0)
                begin
                    id = task_t'(pick);
                    if ($urandom_range(0, 99) < 85)
                        pr = queued_level[pick];
                end
                send_op(FN_REMOVE, id, pr);
            end
        end
    endtask

    initial
    begin
        lvl_map = '0;
        for (int i = 0; i < LEVELS; i++)
        begin
            lvl_head[i] = NONE_LINK;
            lvl_tail[i] = NONE_LINK;
        end
        for (int i = 0; i < SLOTS; i++)
        begin
            nxt[i]          = NONE_LINK;
            prv[i]          = NONE_LINK;
            queued[i]       = 1'b0;
            queued_level[i] = '0;
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle = 7;
        recv_idle = 57;
        test_empty_queue();
        test_fifo_and_priority();
        test_duplicate_push();
        test_remove_rules();
        test_random_mix(135, 1'b1);

        send_idle = 57;
        recv_idle = 7;
        test_random_mix(135, 1'b0);

        send_idle = 0;
        recv_idle = 0;
        test_random_mix(135, 1'b0);

        drain_results();
        // let any stray beat surface before the verdict
        repeat (20) @(posedge clk);

        if (errors == 0)
            $display("priority_fifo_ready_queue_tb: PASS");
        else
            $display("priority_fifo_ready_queue_tb: FAIL");
        $finish;
    end

endmodule
